FILE: rtl/response_frame_checker_assert.svh
// Assertion macros for the response frame checker RTL.
`ifndef RESPONSE_FRAME_CHECKER_ASSERT_SVH
`define RESPONSE_FRAME_CHECKER_ASSERT_SVH
// Same-cycle implication, masked while reset is high.
`define RFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, masked while reset is high.
`define RFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
// Next-cycle implication that also covers the reset cycles.
`define RFC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/rfc_pkg.sv
// Types and constants shared by the response frame checker modules.
`timescale 1ns / 1ps
package rfc_pkg;

   // register map (byte addresses)
   localparam logic [1:0]  CSR_ADDR_POLY  = 2'd0;
   localparam logic [15:0] CRC_POLY_RESET = 16'h8408;
   localparam logic [15:0] CRC_INIT       = 16'h0000;
   localparam logic [15:0] CRC_LSB_MASK   = 16'h0001;

   // status codes that mark an error
   localparam logic [7:0] ST_30 = 8'h30;
   localparam logic [7:0] ST_40 = 8'h40;
   localparam logic [7:0] ST_45 = 8'h45;
   localparam logic [7:0] ST_46 = 8'h46;
   localparam logic [7:0] ST_47 = 8'h47;
   localparam logic [7:0] ST_1C = 8'h1C;

   // sub-codes reported in place of status 0x47
   localparam logic [7:0] SUB47_LO  = 8'h50;
   localparam logic [7:0] SUB47_HI  = 8'h56;
   localparam logic [7:0] SUB47_ONE = 8'h5F;

   // sub-codes reported in place of status 0x1C
   localparam logic [7:0] SUB1C_LO   = 8'h60;
   localparam logic [7:0] SUB1C_HI   = 8'h6A;
   localparam logic [7:0] SUB1C_ONE  = 8'h6C;
   localparam logic [7:0] SUB1C_TWO  = 8'h6D;
   localparam logic [7:0] SUB1C_HLO  = 8'h92;
   localparam logic [7:0] SUB1C_HHI  = 8'h95;

   // one finished frame, front to back
   typedef struct packed {
      logic       crc_ok;
      logic [7:0] status_byte;
      logic [7:0] sub_byte;
   } summary_type;

   // one classified result
   typedef struct packed {
      logic       crc_ok;
      logic [7:0] status_byte;
      logic [7:0] sub_byte;
      logic       fault_flag;
      logic [7:0] error_value;
   } result_type;

   // queue status toward both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

FILE: rtl/response_frame_checker.sv
// Top level of the response frame checker: CSR port, front end, queue, back end.
`timescale 1ns / 1ps
// Checks response frames from a serial link, one byte per transfer on the
// req_ side with req_end_of_frame on the last byte. A reflected CRC-16
// (init 0, polynomial from the crc_poly CSR at byte address 0, reset 0x8408)
// runs over all bytes but the final two, which carry the received CRC low
// byte first. Byte 3 is the status, byte 4 the sub-code (0 when absent).
// Each frame yields one rsp_ transfer: crc_ok, status, sub-code, error flag
// and error value. Rate: one byte per clock while full is low; the CRC
// update is an unrolled 8-step fold of the previously held byte, done in
// the cycle the next non-final byte is taken. full rises only when the
// summary queue (QUEUE_DEPTH entries) is full and the output register
// still holds an unread result. A result goes through the summary queue
// and then the output register. Frames shorter than two bytes report
// crc_ok = 0. Write crc_poly only while no frame is in flight.
module response_frame_checker #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_frame,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic        rsp_crc_ok,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_sub_byte,
   output logic        rsp_fault_flag,
   output logic [7:0]  rsp_error_value,
   // CSR port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0]          poly_ff, poly_in;
   logic                 csr_wr;
   logic                 byte_xfer;
   logic                 sum_push;
   logic                 sum_pop;
   rfc_pkg::summary_type sum_wr;
   rfc_pkg::summary_type sum_rd;
   rfc_pkg::q_stat_type  q_stat;
   rfc_pkg::result_type  res;
   logic                 res_valid;
   logic                 rsp_st_subst;   // status whose value may come from the sub-code
   logic                 rsp_st_listed;  // status is one of the error codes

   // CSR: single register, no wait states
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == rfc_pkg::CSR_ADDR_POLY);
   assign poly_in = csr_wr ? pwdata[15:0] : poly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= rfc_pkg::CRC_POLY_RESET;
      end else begin
         poly_ff <= poly_in;
      end
   end

   assign prdata = (paddr == rfc_pkg::CSR_ADDR_POLY) ? {16'h0000, poly_ff} : 32'h0000_0000;

   // front end takes a byte whenever the queue has room
   assign full      = q_stat.full;
   assign byte_xfer = push && !q_stat.full;

   rfc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .crc_poly     (poly_ff),
      .byte_valid   (byte_xfer),
      .rx_byte      (req_rx_byte),
      .end_of_frame (req_end_of_frame),
      .sum_push     (sum_push),
      .sum_data     (sum_wr)
   );

   rfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (sum_push),
      .push_data (sum_wr),
      .pop       (sum_pop),
      .pop_data  (sum_rd),
      .stat      (q_stat)
   );

   rfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .sum_data  (sum_rd),
      .sum_avail (!q_stat.empty),
      .sum_pop   (sum_pop),
      .res_data  (res),
      .res_valid (res_valid),
      .res_pop   (pop)
   );

   assign empty           = !res_valid;
   assign rsp_crc_ok      = res.crc_ok;
   assign rsp_status_byte = res.status_byte;
   assign rsp_sub_byte    = res.sub_byte;
   assign rsp_fault_flag  = res.fault_flag;
   assign rsp_error_value = res.error_value;

   assign rsp_st_subst  = (rsp_status_byte == rfc_pkg::ST_47) ||
                          (rsp_status_byte == rfc_pkg::ST_1C);
   assign rsp_st_listed = rsp_st_subst ||
                          (rsp_status_byte == rfc_pkg::ST_30) ||
                          (rsp_status_byte == rfc_pkg::ST_40) ||
                          (rsp_status_byte == rfc_pkg::ST_45) ||
                          (rsp_status_byte == rfc_pkg::ST_46);

`include "response_frame_checker_assert.svh"

   // error flag only for the listed status codes
   `RFC_ASSERT_NOW(a_err_status, clock, reset, !empty && rsp_fault_flag, rsp_st_listed, "error flag on non-error status")

   // sub-code substitution only for status 0x47 and 0x1C
   `RFC_ASSERT_NOW(a_err_subst, clock, reset, !empty && (rsp_error_value != rsp_status_byte), rsp_fault_flag && rsp_st_subst, "error value substituted for wrong status")

   // an end-of-frame transfer always leaves a summary queued
   `RFC_ASSERT_NEXT(a_eof_queued, clock, reset, push && !full && req_end_of_frame, !q_stat.empty, "end of frame lost")

   // both sides come out of reset idle
   `RFC_ASSERT_ALWAYS_NEXT(a_reset_idle, clock, reset, empty && !full, "not idle after reset")

endmodule

FILE: rtl/rfc_front.sv
// Frame front end: byte counting, CRC accumulation and field capture.
`timescale 1ns / 1ps
module rfc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          crc_poly,
   input  logic                 byte_valid,
   input  logic [7:0]           rx_byte,
   input  logic                 end_of_frame,
   output logic                 sum_push,
   output rfc_pkg::summary_type sum_data
);

   localparam logic [2:0] CNT_STATUS = 3'd3;
   localparam logic [2:0] CNT_SUB    = 3'd4;
   localparam logic [2:0] CNT_MAX    = 3'd5;

   logic [15:0] crc_ff,    crc_in;
   logic [7:0]  held_ff,   held_in;
   logic [2:0]  count_ff,  count_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  sub_ff,    sub_in;
   logic [7:0]  st_now;
   logic [7:0]  sub_now;
   logic        crc_match;

   // reflected CRC-16, one byte, LSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                            input logic [7:0]  b,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if ((c & rfc_pkg::CRC_LSB_MASK) != 16'h0000) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   assign st_now    = (count_ff == CNT_STATUS) ? rx_byte : status_ff;
   assign sub_now   = (count_ff == CNT_SUB)    ? rx_byte : sub_ff;
   assign crc_match = (count_ff != 3'd0) && ({rx_byte, held_ff} == crc_ff);

   always_comb begin
      crc_in    = crc_ff;
      held_in   = held_ff;
      count_in  = count_ff;
      status_in = status_ff;
      sub_in    = sub_ff;
      if (byte_valid) begin
         if (end_of_frame) begin
            crc_in    = rfc_pkg::CRC_INIT;
            held_in   = 8'h00;
            count_in  = 3'd0;
            status_in = 8'h00;
            sub_in    = 8'h00;
         end else begin
            if (count_ff != 3'd0) begin
               crc_in = crc_feed(crc_ff, held_ff, crc_poly);
            end
            held_in   = rx_byte;
            status_in = st_now;
            sub_in    = sub_now;
            if (count_ff < CNT_MAX) begin
               count_in = count_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= rfc_pkg::CRC_INIT;
         held_ff   <= 8'h00;
         count_ff  <= 3'd0;
         status_ff <= 8'h00;
         sub_ff    <= 8'h00;
      end else begin
         crc_ff    <= crc_in;
         held_ff   <= held_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         sub_ff    <= sub_in;
      end
   end

   assign sum_push             = byte_valid & end_of_frame;
   assign sum_data.crc_ok      = crc_match;
   assign sum_data.status_byte = st_now;
   assign sum_data.sub_byte    = sub_now;

endmodule

FILE: rtl/rfc_queue.sv
// Short queue of frame summaries between the front and back ends.
`timescale 1ns / 1ps
module rfc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rfc_pkg::summary_type push_data,
   input  logic                 pop,
   output rfc_pkg::summary_type pop_data,
   output rfc_pkg::q_stat_type  stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rfc_pkg::summary_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data   = slot_ff[rd_ff];
   assign stat.full  = (cnt_ff == CNT_FULL);
   assign stat.empty = (cnt_ff == '0);

endmodule

FILE: rtl/rfc_back.sv
// Frame back end: status classification and the result output register.
`timescale 1ns / 1ps
module rfc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rfc_pkg::summary_type sum_data,
   input  logic                 sum_avail,
   output logic                 sum_pop,
   output rfc_pkg::result_type  res_data,
   output logic                 res_valid,
   input  logic                 res_pop
);

   logic                valid_ff, valid_in;
   rfc_pkg::result_type res_ff;
   rfc_pkg::result_type res_in;

   always_comb begin
      logic [7:0] st;
      logic [7:0] sb;
      st = sum_data.status_byte;
      sb = sum_data.sub_byte;
      res_in.crc_ok      = sum_data.crc_ok;
      res_in.status_byte = st;
      res_in.sub_byte    = sb;
      res_in.fault_flag  = 1'b0;
      res_in.error_value = st;
      case (st)
         rfc_pkg::ST_30, rfc_pkg::ST_40, rfc_pkg::ST_45, rfc_pkg::ST_46: begin
            res_in.fault_flag = 1'b1;
         end
         rfc_pkg::ST_47: begin
            res_in.fault_flag = 1'b1;
            if ((sb >= rfc_pkg::SUB47_LO && sb <= rfc_pkg::SUB47_HI) ||
                sb == rfc_pkg::SUB47_ONE) begin
               res_in.error_value = sb;
            end
         end
         rfc_pkg::ST_1C: begin
            res_in.fault_flag = 1'b1;
            if ((sb >= rfc_pkg::SUB1C_LO && sb <= rfc_pkg::SUB1C_HI) ||
                sb == rfc_pkg::SUB1C_ONE || sb == rfc_pkg::SUB1C_TWO ||
                (sb >= rfc_pkg::SUB1C_HLO && sb <= rfc_pkg::SUB1C_HHI)) begin
               res_in.error_value = sb;
            end
         end
         default: begin
            res_in.fault_flag = 1'b0;
         end
      endcase
   end

   // refill the output register when it is free or being drained
   assign sum_pop = sum_avail && (!valid_ff || res_pop);

   always_comb begin
      valid_in = valid_ff;
      if (sum_pop) begin
         valid_in = 1'b1;
      end else if (res_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_pop) begin
         res_ff <= res_in;
      end
   end

   assign res_data  = res_ff;
   assign res_valid = valid_ff;

endmodule

FILE: tb/sv/tb_response_frame_checker.sv
// Testbench for the response frame checker: predicts each frame result and checks it.
`timescale 1ns / 1ps
// Frames go in one byte per transfer on the push/full side. A predictor runs
// the CRC fold, the byte 3 and byte 4 capture and the status classification
// per accepted byte. At each end-of-frame byte it queues the result that the
// pop/empty side must hand out next. The crc_poly CSR is rewritten between
// phases, only once the result queue has drained. Phases vary the idle
// pattern on both sides. One phase holds the result side off long enough
// that the block fills up and stalls its input.
module tb_response_frame_checker;

   localparam int STALL_LIMIT    = 4000; // cycles without any transfer
   localparam int SETTLE_CYCLES  = 6;    // result latency plus margin
   localparam int HOLD_OFF       = 300;  // long result-side stall
   localparam int PHASE_BYTES    = 165;
   localparam int NUM_PHASES     = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_end_of_frame = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_crc_ok;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_sub_byte;
   logic        rsp_fault_flag;
   logic [7:0]  rsp_error_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = rfc_pkg::CSR_ADDR_POLY;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   response_frame_checker u_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_rx_byte      (req_rx_byte),
      .req_end_of_frame (req_end_of_frame),
      .empty            (empty),
      .pop              (pop),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_sub_byte     (rsp_sub_byte),
      .rsp_fault_flag   (rsp_fault_flag),
      .rsp_error_value  (rsp_error_value),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial forever #5 clock = ~clock;

   // predictor state: mirrors one frame in flight plus the polynomial CSR
   logic [15:0] poly_model = rfc_pkg::CRC_POLY_RESET;
   logic [15:0] frm_crc    = rfc_pkg::CRC_INIT;
   logic [7:0]  frm_held   = 8'h00;
   logic [2:0]  frm_count  = 3'd0;
   logic [7:0]  frm_status = 8'h00;
   logic [7:0]  frm_sub    = 8'h00;

   rfc_pkg::result_type pending_results[$];  // frame results not yet popped
   logic [7:0]  frame_buf[$];        // frame under construction
   int          mismatch_count = 0;
   int          bytes_sent = 0;
   int          send_idle_pct = 0;   // chance per cycle that the sender idles
   int          rsp_stall_pct = 0;   // chance per cycle that pop stays low
   int          hold_request = 0;    // asks the result side for a long stall

   // reflected CRC-16 fold of one byte, LSB first
   function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      return c;
   endfunction

   // error flag and reported code for a status/sub-code pair
   function automatic logic [7:0] status_verdict(input logic [7:0] st,
                                                 input logic [7:0] sub,
                                                 output logic err);
      err = 1'b1;
      case (st)
         rfc_pkg::ST_30, rfc_pkg::ST_40, rfc_pkg::ST_45, rfc_pkg::ST_46: return st;
         rfc_pkg::ST_47: begin
            if ((sub >= rfc_pkg::SUB47_LO && sub <= rfc_pkg::SUB47_HI) ||
                sub == rfc_pkg::SUB47_ONE)
               return sub;
            return st;
         end
         rfc_pkg::ST_1C: begin
            if ((sub >= rfc_pkg::SUB1C_LO && sub <= rfc_pkg::SUB1C_HI) ||
                sub == rfc_pkg::SUB1C_ONE || sub == rfc_pkg::SUB1C_TWO ||
                (sub >= rfc_pkg::SUB1C_HLO && sub <= rfc_pkg::SUB1C_HHI))
               return sub;
            return st;
         end
         default: begin
            err = 1'b0;
            return st;
         end
      endcase
   endfunction

   // advance the frame model by one accepted byte; queue a result on the last one
   function automatic void predict_frame_byte(input logic [7:0] b, input logic eof);
      logic [7:0] st;
      logic [7:0] sub;
      rfc_pkg::result_type r;
      st  = (frm_count == 3'd3) ? b : frm_status;
      sub = (frm_count == 3'd4) ? b : frm_sub;
      if (!eof) begin
         // the held byte is payload only once a non-final byte follows it
         if (frm_count >= 3'd1)
            frm_crc = crc_fold(frm_crc, frm_held, poly_model);
         frm_held   = b;
         frm_status = st;
         frm_sub    = sub;
         if (frm_count < 3'd5)
            frm_count = frm_count + 3'd1;
      end else begin
         // a single-byte frame has no CRC to compare and always fails
         r.crc_ok      = (frm_count >= 3'd1) && ({b, frm_held} == frm_crc);
         r.status_byte = st;
         r.sub_byte    = sub;
         r.error_value = status_verdict(st, sub, r.fault_flag);
         pending_results.insert(pending_results.size(), r);
         frm_crc    = rfc_pkg::CRC_INIT;
         frm_held   = 8'h00;
         frm_count  = 3'd0;
         frm_status = 8'h00;
         frm_sub    = 8'h00;
      end
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // one byte transfer, then an optional idle gap on the sender side
   task automatic send_byte(input logic [7:0] b, input logic eof);
      int gap;
      req_rx_byte      <= b;
      req_end_of_frame <= eof;
      push             <= 1'b1;
      do @(posedge clock); while (full !== 1'b0);
      predict_frame_byte(b, eof);
      bytes_sent++;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sends frame_buf, optionally with its CRC appended and one bit flipped
   task automatic send_frame_buf(input bit add_crc, input bit corrupt);
      logic [15:0] c;
      int pos;
      c = rfc_pkg::CRC_INIT;
      for (int i = 0; i < frame_buf.size(); i++)
         c = crc_fold(c, frame_buf[i], poly_model);
      if (add_crc) begin
         frame_buf.insert(frame_buf.size(), c[7:0]);
         frame_buf.insert(frame_buf.size(), c[15:8]);
      end
      if (corrupt) begin
         pos = $urandom_range(0, frame_buf.size() - 1);
         frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frame_buf.delete();
   endtask

   task automatic csr_write(input logic [15:0] poly);
      logic [15:0] junk;
      junk = 16'($urandom);   // upper bits must be dropped
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= rfc_pkg::CSR_ADDR_POLY;
      pwdata  <= {junk, poly};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      poly_model = poly;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_poly();
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= rfc_pkg::CSR_ADDR_POLY;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got = prdata;
      check_field("crc_poly", poly_model, got[15:0]);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // sender stops and waits until every predicted result has been popped
   task automatic wait_results_drained();
      if (push)
         push <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_status();
      logic [7:0] codes [6];
      codes = '{rfc_pkg::ST_30, rfc_pkg::ST_40, rfc_pkg::ST_45, rfc_pkg::ST_46,
                rfc_pkg::ST_47, rfc_pkg::ST_1C};
      if ($urandom_range(0, 1))
         return codes[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   // sub-codes near the edges of the ranges that replace the status
   function automatic logic [7:0] pick_sub(input logic [7:0] st);
      if (st == rfc_pkg::ST_47 && $urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 7))
            0: return rfc_pkg::SUB47_LO - 8'd1;
            1: return rfc_pkg::SUB47_LO;
            2: return 8'($urandom_range(rfc_pkg::SUB47_LO, rfc_pkg::SUB47_HI));
            3: return rfc_pkg::SUB47_HI;
            4: return rfc_pkg::SUB47_HI + 8'd1;
            5: return rfc_pkg::SUB47_ONE - 8'd1;
            6: return rfc_pkg::SUB47_ONE;
            default: return rfc_pkg::SUB47_ONE + 8'd1;
         endcase
      end
      if (st == rfc_pkg::ST_1C && $urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 11))
            0: return rfc_pkg::SUB1C_LO - 8'd1;
            1: return rfc_pkg::SUB1C_LO;
            2: return 8'($urandom_range(rfc_pkg::SUB1C_LO, rfc_pkg::SUB1C_HI));
            3: return rfc_pkg::SUB1C_HI;
            4: return rfc_pkg::SUB1C_HI + 8'd1;
            5: return rfc_pkg::SUB1C_ONE;
            6: return rfc_pkg::SUB1C_TWO;
            7: return rfc_pkg::SUB1C_TWO + 8'd1;
            8: return rfc_pkg::SUB1C_HLO - 8'd1;
            9: return 8'($urandom_range(rfc_pkg::SUB1C_HLO, rfc_pkg::SUB1C_HHI));
            10: return rfc_pkg::SUB1C_HHI;
            default: return rfc_pkg::SUB1C_HHI + 8'd1;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly well-formed frames, some with a flipped bit, some plain noise
   task automatic send_random_frame();
      int kind;
      int len;
      logic [7:0] rnd;
      logic [7:0] st;
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 7);
      if (kind < 15)
         len = $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
         rnd = 8'($urandom_range(0, 255));
         frame_buf.insert(frame_buf.size(), rnd);
      end
      if (kind < 15) begin
         send_frame_buf(1'b0, 1'b0);
      end else begin
         if (len > 3) begin
            st = pick_status();
            frame_buf[3] = st;
            if (len > 4)
               frame_buf[4] = pick_sub(st);
         end
         send_frame_buf(1'b1, kind < 30);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_poly_reset_value();
      csr_check_poly();
   endtask

   // one-byte frame, empty payload, and a frame too short to have a status
   task automatic test_short_frames();
      frame_buf.insert(frame_buf.size(), 8'hFF);
      send_frame_buf(1'b0, 1'b0);
      send_frame_buf(1'b1, 1'b0);
      frame_buf.insert(frame_buf.size(), 8'h00);
      send_frame_buf(1'b1, 1'b0);
   endtask

   // status codes whose reported value comes from the sub-code
   task automatic test_error_codes();
      frame_buf = '{8'h02, 8'h07, 8'h00, rfc_pkg::ST_47, rfc_pkg::SUB47_ONE};
      send_frame_buf(1'b1, 1'b0);
      frame_buf = '{8'h02, 8'h07, 8'h00, rfc_pkg::ST_1C, rfc_pkg::SUB1C_HHI};
      send_frame_buf(1'b1, 1'b0);
   endtask

   // result side stalls long enough for the input to back up
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = HOLD_OFF;
      repeat (25) send_random_frame();
      wait_results_drained();
   endtask

   task automatic test_random_traffic();
      logic [15:0] polys [NUM_PHASES];
      int start;
      polys = '{16'h0000, 16'hFFFF, rfc_pkg::CRC_POLY_RESET, 16'h0001, 16'h8000,
                16'hA001, 16'h0000, 16'h0000};
      polys[6] = 16'($urandom);
      polys[7] = 16'($urandom);
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_results_drained();
         csr_write(polys[phase]);
         csr_check_poly();
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES)
            send_random_frame();
      end
   endtask

   // ------------------------------------------------------ result side

   initial begin : result_monitor
      rfc_pkg::result_type want;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && empty === 1'b0) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no frame result pending");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("crc_ok", 16'(want.crc_ok), 16'(rsp_crc_ok));
               check_field("status_byte", 16'(want.status_byte), 16'(rsp_status_byte));
               check_field("sub_byte", 16'(want.sub_byte), 16'(rsp_sub_byte));
               check_field("fault_flag", 16'(want.fault_flag), 16'(rsp_fault_flag));
               check_field("error_value", 16'(want.error_value), 16'(rsp_error_value));
            end
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // ends the run when neither side has moved for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && full === 1'b0) || (pop && empty === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_response_frame_checker: done, errors");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_poly_reset_value();
      test_short_frames();
      test_error_codes();
      test_backpressure();
      test_random_traffic();
      wait_results_drained();
      if (mismatch_count == 0) begin
         $display("tb_response_frame_checker: done, clean");
      end else begin
         $display("tb_response_frame_checker: done, errors");
      end
      $finish;
   end

endmodule
